// ===== rtl/core/pfxe_pkg.sv =====
package pfxe_pkg;

  // Data word, default stack size, error sentinel and minimum operand count
  localparam int unsigned WordW       = 32;
  localparam int unsigned StackDepth  = 64;
  localparam int unsigned SentinelVal = 1000000000;
  localparam int unsigned MinOperands = 2;

  // Request codes on req_type
  typedef enum logic [2:0] {
    REQ_PUSH = 3'd0,
    REQ_ADD  = 3'd1,
    REQ_SUB  = 3'd2,
    REQ_MUL  = 3'd3,
    REQ_DIV  = 3'd4,
    REQ_MOD  = 3'd5,
    REQ_END  = 3'd6
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_MODZERO   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_DIV  = 2'd2,
    S_EMIT = 2'd3
  } state_e;

  // Divider result bundle
  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quotient;
    logic [WordW-1:0] remainder;
  } div_res_t;

endpackage

// ===== rtl/core/postfix_expression_evaluator_core.sv =====
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | in_req_type_i, in_number_i
// out     | output    | out_valid_o / out_stall_i  | out_status_o, out_value_o
//
// Push, end and dropped requests are handled in the idle state. Add, sub,
// mul, div and mod read the second operand from stack memory (top of stack
// sits in a register); div and mod wait on the one-bit-per-cycle divider.
// Reset clears depth, discard flag and handshake state; no memory clearing.
// Input is taken while a result waits on a stalled output; a second result
// holds in a pending register until the output frees up.
module postfix_expression_evaluator_core #(
  parameter int unsigned STACK_DEPTH = pfxe_pkg::StackDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        in_req_type_i,
  input  logic signed [pfxe_pkg::WordW-1:0] in_number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        out_status_o,
  output logic signed [pfxe_pkg::WordW-1:0] out_value_o
);

  localparam int unsigned W  = pfxe_pkg::WordW;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam logic [W-1:0] Sentinel = W'(pfxe_pkg::SentinelVal);

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (W'(0) - v) : v;
  endfunction

  pfxe_pkg::state_e  state_q, state_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic              discard_q, discard_d;
  logic [W-1:0]      tos_q, tos_d;
  pfxe_pkg::req_e    op_q, op_d;
  logic              neg_q, neg_d;
  logic              out_valid_q;
  pfxe_pkg::status_e out_status_q;
  logic [W-1:0]      out_value_q;
  pfxe_pkg::status_e pend_status_q;
  logic [W-1:0]      pend_value_q;

  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic              emit_req;
  pfxe_pkg::status_e emit_status;
  logic [W-1:0]      emit_value;
  logic              go_read;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [W-1:0]      mem_wdata, mem_rdata;
  logic              div_start;
  logic [W-1:0]      div_a, div_b;
  pfxe_pkg::div_res_t div_res;
  pfxe_pkg::req_e    req;
  logic [W-1:0]      opa, opb;

  assign in_stall_o = (state_q != pfxe_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign req        = pfxe_pkg::req_e'(in_req_type_i);
  assign opa        = mem_rdata;
  assign opb        = tos_q;

  pfxe_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  pfxe_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .res_o     (div_res)
  );

  // Datapath: stack update, result generation, memory and divider control
  always_comb begin
    depth_d     = depth_q;
    discard_d   = discard_q;
    tos_d       = tos_q;
    op_d        = op_q;
    neg_d       = neg_q;
    emit_req    = 1'b0;
    emit_status = pfxe_pkg::ST_OK;
    go_read     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(depth_q - DW'(1));
    mem_wdata   = tos_q;
    mem_re      = 1'b0;
    mem_raddr   = AW'(depth_q - DW'(pfxe_pkg::MinOperands));
    div_start   = 1'b0;
    div_a       = mag(opa);
    div_b       = mag(opb);
    unique case (state_q)
      pfxe_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (req)
            pfxe_pkg::REQ_PUSH: begin
              if (!discard_q) begin
                if (depth_q == DW'(STACK_DEPTH)) begin
                  emit_req    = 1'b1;
                  emit_status = pfxe_pkg::ST_OVERFLOW;
                  discard_d   = 1'b1;
                end else begin
                  // old top goes down into memory
                  mem_we  = (depth_q != '0);
                  tos_d   = in_number_i;
                  depth_d = depth_q + DW'(1);
                end
              end
            end
            pfxe_pkg::REQ_ADD, pfxe_pkg::REQ_SUB, pfxe_pkg::REQ_MUL,
            pfxe_pkg::REQ_DIV, pfxe_pkg::REQ_MOD: begin
              if (!discard_q) begin
                if (depth_q < DW'(pfxe_pkg::MinOperands)) begin
                  emit_req    = 1'b1;
                  emit_status = pfxe_pkg::ST_MALFORMED;
                  discard_d   = 1'b1;
                end else begin
                  mem_re  = 1'b1;
                  op_d    = req;
                  go_read = 1'b1;
                end
              end
            end
            pfxe_pkg::REQ_END: begin
              depth_d   = '0;
              discard_d = 1'b0;
              if (!discard_q) begin
                emit_req    = 1'b1;
                emit_status = (depth_q == DW'(1)) ? pfxe_pkg::ST_OK
                                                  : pfxe_pkg::ST_MALFORMED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pfxe_pkg::S_READ: begin
        unique case (op_q)
          pfxe_pkg::REQ_ADD: begin
            tos_d   = opa + opb;
            depth_d = depth_q - DW'(1);
          end
          pfxe_pkg::REQ_SUB: begin
            tos_d   = opa - opb;
            depth_d = depth_q - DW'(1);
          end
          pfxe_pkg::REQ_MUL: begin
            tos_d   = opa * opb;
            depth_d = depth_q - DW'(1);
          end
          pfxe_pkg::REQ_DIV, pfxe_pkg::REQ_MOD: begin
            if (opb == '0) begin
              emit_req    = 1'b1;
              emit_status = (op_q == pfxe_pkg::REQ_DIV) ? pfxe_pkg::ST_DIVZERO
                                                        : pfxe_pkg::ST_MODZERO;
              discard_d   = 1'b1;
            end else begin
              div_start = 1'b1;
              // quotient sign from both operands, remainder from dividend
              neg_d = (op_q == pfxe_pkg::REQ_DIV) ? (opa[W-1] ^ opb[W-1])
                                                  : opa[W-1];
            end
          end
          default: begin
          end
        endcase
      end
      pfxe_pkg::S_DIV: begin
        if (div_res.done) begin
          if (op_q == pfxe_pkg::REQ_DIV) begin
            tos_d = neg_q ? (W'(0) - div_res.quotient) : div_res.quotient;
          end else begin
            tos_d = neg_q ? (W'(0) - div_res.remainder) : div_res.remainder;
          end
          depth_d = depth_q - DW'(1);
        end
      end
      pfxe_pkg::S_EMIT: begin
      end
      default: begin
      end
    endcase
    emit_value = (emit_status == pfxe_pkg::ST_OK) ? tos_q : Sentinel;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfxe_pkg::S_IDLE: begin
        if (go_read) begin
          state_d = pfxe_pkg::S_READ;
        end else if (emit_req && !out_free) begin
          state_d = pfxe_pkg::S_EMIT;
        end
      end
      pfxe_pkg::S_READ: begin
        if (div_start) begin
          state_d = pfxe_pkg::S_DIV;
        end else if (emit_req && !out_free) begin
          state_d = pfxe_pkg::S_EMIT;
        end else begin
          state_d = pfxe_pkg::S_IDLE;
        end
      end
      pfxe_pkg::S_DIV: begin
        if (div_res.done) begin
          state_d = pfxe_pkg::S_IDLE;
        end
      end
      pfxe_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = pfxe_pkg::S_IDLE;
        end
      end
      default: state_d = pfxe_pkg::S_IDLE;
    endcase
  end

  // Output register load: fresh result or the pending one
  assign out_load = out_free && (emit_req || (state_q == pfxe_pkg::S_EMIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfxe_pkg::S_IDLE;
      depth_q     <= '0;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      depth_q   <= depth_d;
      discard_q <= discard_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    op_q  <= op_d;
    neg_q <= neg_d;
    if (emit_req) begin
      pend_status_q <= emit_status;
      pend_value_q  <= emit_value;
    end
    if (out_load) begin
      if (emit_req) begin
        out_status_q <= emit_status;
        out_value_q  <= emit_value;
      end else begin
        out_status_q <= pend_status_q;
        out_value_q  <= pend_value_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;

  // Stack depth never passes its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth above capacity");

  // Any error result carries the sentinel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != pfxe_pkg::ST_OK) |-> (out_value_o == Sentinel))
    else $error("error result without sentinel");

  // Divider only finishes while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == pfxe_pkg::S_DIV))
    else $error("divider done outside divide state");

  // Discarded requests leave the depth alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && discard_q && in_req_type_i != pfxe_pkg::REQ_END) |=> $stable(depth_q))
    else $error("depth changed while discarding");

endmodule

// ===== rtl/core/pfxe_stack_mem.sv =====
module pfxe_stack_mem #(
  parameter int unsigned STACK_DEPTH = pfxe_pkg::StackDepth
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] waddr_i,
  input  logic [pfxe_pkg::WordW-1:0]     wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr_i,
  output logic [pfxe_pkg::WordW-1:0]     rdata_o
);

  logic [pfxe_pkg::WordW-1:0] mem [STACK_DEPTH];
  logic [pfxe_pkg::WordW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pfxe_divider.sv =====
module pfxe_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pfxe_pkg::WordW-1:0] dividend_i,
  input  logic [pfxe_pkg::WordW-1:0] divisor_i,
  output pfxe_pkg::div_res_t         res_o
);

  localparam int unsigned W  = pfxe_pkg::WordW;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // One restoring step per cycle
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned RandomItems = 160;
  localparam logic [2:0]  REQ_UNUSED  = 3'd7;
  localparam logic [31:0] IntMin      = 32'h8000_0000;
  localparam logic [31:0] IntMax      = 32'h7fff_ffff;

  typedef struct {
    pfxe_pkg::status_e status;
    logic [31:0]       value;
  } calc_result_t;

  // DUT signals, all inputs known from time zero
  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic [2:0]                        in_req_type_i = pfxe_pkg::REQ_PUSH;
  logic signed [pfxe_pkg::WordW-1:0] in_number_i   = '0;
  logic                              out_stall_i   = 1'b0;
  logic                              in_stall_o;
  logic                              out_valid_o;
  logic [2:0]                        out_status_o;
  logic signed [pfxe_pkg::WordW-1:0] out_value_o;

  // Calculator state mirrored by the predictor
  logic [31:0] calc_stack [pfxe_pkg::StackDepth];
  int unsigned calc_depth   = 0;
  bit          calc_discard = 1'b0;

  calc_result_t expected_results [$];

  bit          in_idle_en      = 1'b1;
  bit          out_idle_en     = 1'b1;
  int unsigned tokens_sent     = 0;
  int unsigned effective_items = 0;
  int unsigned results_checked = 0;
  int unsigned error_count     = 0;
  int unsigned status_seen [0:4];
  int unsigned stall_left      = 0;
  int unsigned idle_cycles     = 0;

  postfix_expression_evaluator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_type_i (in_req_type_i),
    .in_number_i   (in_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_status_o  (out_status_o),
    .out_value_o   (out_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Error exit: flag, return the sentinel, drop tokens until end
  function automatic bit flag_error(input pfxe_pkg::status_e st,
                                    output calc_result_t res);
    calc_discard = 1'b1;
    res.status   = st;
    res.value    = pfxe_pkg::SentinelVal;
    return 1'b1;
  endfunction

  // Apply one token to the mirrored stack; returns 1 when a result is due
  function automatic bit eval_token(input logic [2:0] tok, input logic [31:0] num,
                                    output calc_result_t res);
    logic [31:0] lhs, rhs, mag_l, mag_r, acc;
    bit          was_discard;
    int unsigned old_depth;
    res.status = pfxe_pkg::ST_OK;
    res.value  = '0;
    if (tok == REQ_UNUSED) return 1'b0;
    if (tok == pfxe_pkg::REQ_END) begin
      was_discard  = calc_discard;
      old_depth    = calc_depth;
      calc_depth   = 0;
      calc_discard = 1'b0;
      if (was_discard) return 1'b0;
      if (old_depth == 1) begin
        res.value = calc_stack[0];
      end else begin
        res.status = pfxe_pkg::ST_MALFORMED;
        res.value  = pfxe_pkg::SentinelVal;
      end
      return 1'b1;
    end
    if (calc_discard) return 1'b0;
    if (tok == pfxe_pkg::REQ_PUSH) begin
      if (calc_depth >= pfxe_pkg::StackDepth) return flag_error(pfxe_pkg::ST_OVERFLOW, res);
      calc_stack[calc_depth] = num;
      calc_depth++;
      return 1'b0;
    end
    if (calc_depth < pfxe_pkg::MinOperands) return flag_error(pfxe_pkg::ST_MALFORMED, res);
    // top of stack is the right operand
    rhs   = calc_stack[calc_depth-1];
    lhs   = calc_stack[calc_depth-2];
    calc_depth -= 2;
    mag_l = lhs[31] ? -lhs : lhs;
    mag_r = rhs[31] ? -rhs : rhs;
    case (tok)
      pfxe_pkg::REQ_ADD: acc = lhs + rhs;
      pfxe_pkg::REQ_SUB: acc = lhs - rhs;
      pfxe_pkg::REQ_MUL: acc = lhs * rhs;
      pfxe_pkg::REQ_DIV: begin
        if (rhs == '0) return flag_error(pfxe_pkg::ST_DIVZERO, res);
        // truncate toward zero
        acc = mag_l / mag_r;
        if (lhs[31] ^ rhs[31]) acc = -acc;
      end
      default: begin
        if (rhs == '0) return flag_error(pfxe_pkg::ST_MODZERO, res);
        // remainder follows the dividend's sign
        acc = mag_l % mag_r;
        if (lhs[31]) acc = -acc;
      end
    endcase
    calc_stack[calc_depth] = acc;
    calc_depth++;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // Drive one request, hold it until taken, then predict its result
  task automatic send_token(input logic [2:0] tok, input logic [31:0] num);
    int unsigned  gap;
    calc_result_t res;
    gap = in_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_req_type_i <= tok;
    in_number_i   <= num;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tokens_sent++;
    if (tok != REQ_UNUSED && (!calc_discard || tok == pfxe_pkg::REQ_END)) effective_items++;
    if (eval_token(tok, num, res)) expected_results.push_back(res);
  endtask

  // Operands biased toward small values, zero and the extremes
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 20) - 10;
      3:       return '0;
      4:       return IntMin;
      5:       return IntMax;
      6:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic pfxe_pkg::req_e rand_operator();
    return pfxe_pkg::req_e'($urandom_range(pfxe_pkg::REQ_ADD, pfxe_pkg::REQ_MOD));
  endfunction

  // Well-formed expression with random operands and operators
  task automatic send_random_expr(input int unsigned max_operands);
    int unsigned n_operands, pushed, depth;
    n_operands = $urandom_range(1, max_operands);
    pushed     = 0;
    depth      = 0;
    while (pushed < n_operands || depth > 1) begin
      if (pushed < n_operands && (depth < 2 || $urandom_range(0, 1))) begin
        send_token(pfxe_pkg::REQ_PUSH, rand_operand());
        pushed++;
        depth++;
      end else begin
        send_token(rand_operator(), $urandom);
        depth--;
      end
    end
    send_token(pfxe_pkg::REQ_END, $urandom);
  endtask

  // Arbitrary token soup, sometimes left without an end
  task automatic send_noise_expr();
    int unsigned n_tokens;
    n_tokens = $urandom_range(1, 8);
    repeat (n_tokens) begin
      send_token(3'($urandom_range(pfxe_pkg::REQ_PUSH, REQ_UNUSED)), rand_operand());
    end
    if ($urandom_range(0, 3) != 0) send_token(pfxe_pkg::REQ_END, $urandom);
  endtask

  task automatic test_arith_extremes();
    // max + 1 wraps to min
    send_token(pfxe_pkg::REQ_PUSH, IntMax);
    send_token(pfxe_pkg::REQ_PUSH, 32'd1);
    send_token(pfxe_pkg::REQ_ADD, $urandom);
    send_token(pfxe_pkg::REQ_END, $urandom);
    // min / -1 wraps, min mod -1 is zero
    send_token(pfxe_pkg::REQ_PUSH, IntMin);
    send_token(pfxe_pkg::REQ_PUSH, '1);
    send_token(pfxe_pkg::REQ_DIV, $urandom);
    send_token(pfxe_pkg::REQ_END, $urandom);
    send_token(pfxe_pkg::REQ_PUSH, IntMin);
    send_token(pfxe_pkg::REQ_PUSH, '1);
    send_token(pfxe_pkg::REQ_MOD, $urandom);
    send_token(pfxe_pkg::REQ_END, $urandom);
    // truncation, dividend sign, sub and mul wrap in one expression
    send_token(pfxe_pkg::REQ_PUSH, -7);
    send_token(pfxe_pkg::REQ_PUSH, 2);
    send_token(pfxe_pkg::REQ_DIV, $urandom);
    send_token(pfxe_pkg::REQ_PUSH, -7);
    send_token(pfxe_pkg::REQ_PUSH, 2);
    send_token(pfxe_pkg::REQ_MOD, $urandom);
    send_token(pfxe_pkg::REQ_MUL, $urandom);
    send_token(pfxe_pkg::REQ_PUSH, IntMin);
    send_token(pfxe_pkg::REQ_SUB, $urandom);
    send_token(pfxe_pkg::REQ_PUSH, IntMax);
    send_token(pfxe_pkg::REQ_MUL, $urandom);
    send_token(pfxe_pkg::REQ_END, $urandom);
  endtask

  task automatic test_error_paths();
    // too few operands, then the rest is dropped up to end
    send_token(pfxe_pkg::REQ_PUSH, 5);
    send_token(pfxe_pkg::REQ_ADD, $urandom);
    send_token(pfxe_pkg::REQ_PUSH, 3);
    send_token(REQ_UNUSED, $urandom);
    send_token(pfxe_pkg::REQ_MUL, $urandom);
    send_token(pfxe_pkg::REQ_END, $urandom);
    // zero divisors
    send_token(pfxe_pkg::REQ_PUSH, 9);
    send_token(pfxe_pkg::REQ_PUSH, 0);
    send_token(pfxe_pkg::REQ_DIV, $urandom);
    send_token(pfxe_pkg::REQ_END, $urandom);
    send_token(pfxe_pkg::REQ_PUSH, -9);
    send_token(pfxe_pkg::REQ_PUSH, 0);
    send_token(pfxe_pkg::REQ_MOD, $urandom);
    send_token(pfxe_pkg::REQ_END, $urandom);
    // end on empty and on two entries
    send_token(pfxe_pkg::REQ_END, $urandom);
    send_token(pfxe_pkg::REQ_PUSH, 1);
    send_token(pfxe_pkg::REQ_PUSH, 2);
    send_token(pfxe_pkg::REQ_END, $urandom);
    // unused code leaves a live expression alone
    send_token(pfxe_pkg::REQ_PUSH, 4);
    send_token(REQ_UNUSED, $urandom);
    send_token(pfxe_pkg::REQ_END, $urandom);
  endtask

  task automatic test_stack_limits();
    // fill exactly, then fold back to one value
    for (int i = 0; i < pfxe_pkg::StackDepth; i++) begin
      send_token(pfxe_pkg::REQ_PUSH, rand_operand());
    end
    for (int i = 1; i < pfxe_pkg::StackDepth; i++) begin
      send_token(pfxe_pkg::req_e'($urandom_range(pfxe_pkg::REQ_ADD, pfxe_pkg::REQ_MUL)),
                 $urandom);
    end
    send_token(pfxe_pkg::REQ_END, $urandom);
    // one push past full
    for (int i = 0; i <= pfxe_pkg::StackDepth; i++) begin
      send_token(pfxe_pkg::REQ_PUSH, rand_operand());
    end
    send_token(pfxe_pkg::REQ_END, $urandom);
  endtask

  task automatic test_random_expressions();
    int unsigned base;
    base = effective_items;
    for (int phase = 0; phase < 4; phase++) begin
      // both idle, none, sender only, receiver only
      in_idle_en  = (phase == 0 || phase == 2);
      out_idle_en = (phase == 0 || phase == 3);
      while (effective_items - base < RandomItems / 4 * (phase + 1)) begin
        if ($urandom_range(0, 9) < 8) begin
          send_random_expr(($urandom_range(0, 19) == 0) ? pfxe_pkg::StackDepth : 6);
        end else begin
          send_noise_expr();
        end
      end
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Result checker and output stall generator
  always @(posedge clk_i) begin : check_results
    calc_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d value %0d",
                                  out_status_o, out_value_o));
      end else begin
        want = expected_results.pop_front();
        if (out_status_o !== want.status) begin
          report_mismatch($sformatf("status got %0d expected %0d", out_status_o, want.status));
        end
        if (out_value_o !== want.value) begin
          report_mismatch($sformatf("value got %0d expected %0d",
                                    out_value_o, $signed(want.value)));
        end
        results_checked++;
        status_seen[want.status]++;
      end
      stall_left = out_idle_en ? $urandom_range(0, 7) : 0;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles with no traffic on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no request or result moved for %0d cycles, %0d results pending",
                 IdleLimit, expected_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_arith_extremes();
    test_error_paths();
    test_stack_limits();
    test_random_expressions();
    in_valid_i <= 1'b0;
    // drain, then give late extra results a chance to show up
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d requests (%0d acted on), checked %0d results",
             tokens_sent, effective_items, results_checked);
    $display("By status: ok %0d, malformed %0d, div zero %0d, mod zero %0d, overflow %0d",
             status_seen[pfxe_pkg::ST_OK], status_seen[pfxe_pkg::ST_MALFORMED],
             status_seen[pfxe_pkg::ST_DIVZERO], status_seen[pfxe_pkg::ST_MODZERO],
             status_seen[pfxe_pkg::ST_OVERFLOW]);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
